/* rtl/blt_pkg.sv */
package blt_pkg;

    // Input item
    typedef struct packed {
        logic        mode;
        logic [31:0] entry_id;
        logic [47:0] mac_address;
        logic [15:0] flag_bits;
        logic [31:0] now_ticks;
    } t_in;

    // Result item
    typedef struct packed {
        logic        hit;
        logic        present;
        logic [47:0] mac_out;
        logic [15:0] flags_out;
        logic [10:0] live_count;
        logic [10:0] expired_count;
    } t_out;

    // Configuration write
    typedef struct packed {
        logic [1:0]  index;
        logic [30:0] data;
    } t_cfg;

    localparam logic [1:0] CFG_MAX_COUNT     = 2'd0;
    localparam logic [1:0] CFG_FULL_LIFETIME = 2'd1;
    localparam logic [1:0] CFG_UNICAST_MASK  = 2'd2;

    localparam logic [10:0] RST_MAX_COUNT     = 11'd1024;
    localparam logic [30:0] RST_FULL_LIFETIME = 31'd60000;
    localparam logic [15:0] RST_UNICAST_MASK  = 16'd1;

    // Shortened aging timeouts
    localparam logic [30:0] SHORT_TMO = 31'd1000;
    localparam logic [30:0] MID_TMO   = 31'd5000;

endpackage

/* rtl/blt_chan_if.sv */
interface blt_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/blt_ram.sv */
module blt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wa,
    input  logic [WIDTH-1:0]                      i_wd,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_ra,
    output logic [WIDTH-1:0]                      o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, registered read (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

/* rtl/bucketed_learning_table_with_aging.sv */
// Learning table with per-bucket aging.
// Channels: i_in takes items (lookup or update), o_res returns exactly one
// result per item, i_cfg writes the three registers (max count, lifetime,
// unicast mask) by index; it is always ready and must be written by the user
// only while idle, which the block itself does not enforce. Every channel
// moves a transfer on a clock edge with valid and ready high. One item at a
// time: i_in is ready only while no item is in work. Each item walks the
// slot memory, which has one read and one write port:
//   bucket of the id (low bits, BUCKETS is a power of two),
//   key search and free-slot search,
//   write of the updated entry,
// and for an update with a nonzero id in addition
//   bucket tracker clear,
//   scan for the oldest live entry of each bucket,
//   removal scan,
// and at the end loading of the result.
// After reset the block sweeps the slot memory to clear it and takes no item
// meanwhile. A stalled o_res keeps its result; the next item is accepted and
// worked on, and waits for the result register to free.
module bucketed_learning_table_with_aging #(
    parameter int CAPACITY = 1024,
    parameter int BUCKETS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blt_chan_if.sink   i_in,
    blt_chan_if.sink   i_cfg,
    blt_chan_if.source o_res
);
    import blt_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > 11) ? CW : 11;

    typedef struct packed {
        logic          vld;
        logic [31:0]   key;
        logic [BW-1:0] bkt;
        logic [47:0]   mac;
        logic [15:0]   flags;
        logic [31:0]   seen;
        logic [31:0]   rec;
    } t_slot;

    typedef struct packed {
        logic          has;
        logic [31:0]   age;
        logic [IW-1:0] idx;
    } t_trk;

    localparam int SW = $bits(t_slot);
    localparam int TW = $bits(t_trk);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_BKT  = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_UPD  = 9'b000010000,
        S_TCLR = 9'b000100000,
        S_AGE1 = 9'b001000000,
        S_AGE2 = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration
    logic [10:0] r_max_count;
    logic [30:0] r_full_life;
    logic [15:0] r_uc_mask;

    // Request
    logic          r_mode;
    logic [31:0]   r_id;
    logic [47:0]   r_mac;
    logic [15:0]   r_flags;
    logic [31:0]   r_now;
    logic [BW-1:0] r_rem;

    // Search results and target
    logic          r_hit;
    logic [IW-1:0] r_mslot;
    logic [47:0]   r_old_mac;
    logic [15:0]   r_old_flags;
    logic          r_free_v;
    logic [IW-1:0] r_free;
    logic          r_tgt_v;
    logic [IW-1:0] r_tgt;
    logic [47:0]   r_out_mac;
    logic [15:0]   r_out_flags;

    // Table state
    logic [31:0]   r_rc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_exp;
    logic [30:0]   r_base;

    // Scan pipeline
    logic [IW:0]   r_idx;
    logic [BW:0]   r_tidx;
    logic          r_s1_v;
    logic [IW-1:0] r_s1_idx;
    logic          r_s2_v;
    logic [IW-1:0] r_s2_idx;
    logic [BW-1:0] r_s2_bkt;
    logic [31:0]   r_s2_age;
    logic          r_s2_exp;
    t_slot         r_s2_word;
    logic          r_fw_v;
    logic [BW-1:0] r_fw_a;
    t_trk          r_fw_d;

    // Result register
    logic r_ov;
    t_out r_od;

    // Memory ports
    logic          s_we;
    logic [IW-1:0] s_wa;
    t_slot         s_wd;
    logic [SW-1:0] s_rd_raw;
    t_slot         s_rd;
    logic          t_we;
    logic [BW-1:0] t_wa;
    t_trk          t_wd;
    logic [BW-1:0] t_ra;
    logic [TW-1:0] t_rd_raw;
    t_trk          t_rd;

    blt_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
        .i_clk (i_clk),
        .i_we  (s_we),
        .i_wa  (s_wa),
        .i_wd  (s_wd),
        .i_ra  (r_idx[IW-1:0]),
        .o_rd  (s_rd_raw)
    );

    blt_ram #(.WIDTH(TW), .DEPTH(BUCKETS)) u_trk_ram (
        .i_clk (i_clk),
        .i_we  (t_we),
        .i_wa  (t_wa),
        .i_wd  (t_wd),
        .i_ra  (t_ra),
        .o_rd  (t_rd_raw)
    );

    assign s_rd = t_slot'(s_rd_raw);
    assign t_rd = t_trk'(t_rd_raw);

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_od;

    // Scan issue and end of phase
    logic scan_issue;
    logic scan_done;
    assign scan_issue = (r_idx != (IW+1)'(CAPACITY));
    assign scan_done  = !scan_issue && !r_s1_v && !r_s2_v;

    // Stage 1: slot data back from memory
    logic [30:0] s1_tmo;
    logic [31:0] s1_d;
    logic [31:0] s1_age;
    logic        s1_match;
    assign s1_tmo   = (|(s_rd.flags & r_uc_mask)) ? r_full_life : r_base;
    assign s1_d     = s_rd.seen + {1'b0, s1_tmo} - r_now;
    assign s1_age   = r_rc - s_rd.rec;
    assign s1_match = s_rd.vld && (s_rd.key == r_id) && (r_id != 32'd0);

    // Stage 2: tracker entry, with the previous cycle's write forwarded
    t_trk  s2_cur;
    logic  s2_upd;
    logic  s2_rm;
    assign s2_cur = (r_fw_v && (r_fw_a == r_s2_bkt)) ? r_fw_d : t_rd;
    assign s2_upd = r_s2_v && !r_s2_exp && (!s2_cur.has || (r_s2_age > s2_cur.age));
    assign s2_rm  = r_s2_v && r_s2_exp &&
                    (!t_rd.has || (r_s2_age > t_rd.age) ||
                     ((r_s2_age == t_rd.age) && (r_s2_idx < t_rd.idx)));

    // Entry written by an update
    logic [15:0] upd_flags;
    assign upd_flags = r_hit ? (r_old_flags | r_flags) : r_flags;

    // Base timeout from the count after the update
    logic [MW-1:0] cnt_x;
    logic [MW-1:0] max_x;
    assign cnt_x = MW'(r_cnt);
    assign max_x = MW'(r_max_count);

    // Memory write ports
    always_comb begin
        s_we = 1'b0;
        s_wa = r_idx[IW-1:0];
        s_wd = '0;
        t_we = 1'b0;
        t_wa = r_s2_bkt;
        t_wd = '0;
        t_ra = s_rd.bkt;
        unique case (r_state)
            S_CLR: begin
                s_we = 1'b1;
            end
            S_UPD: begin
                s_we = r_mode && (r_id != 32'd0) && (r_hit || r_free_v);
                s_wa = r_hit ? r_mslot : r_free;
                s_wd = '{vld: 1'b1, key: r_id, bkt: r_rem, mac: r_mac,
                         flags: upd_flags, seen: r_now, rec: r_rc};
            end
            S_TCLR: begin
                t_we = 1'b1;
                t_wa = r_tidx[BW-1:0];
            end
            S_AGE1: begin
                t_we = s2_upd;
                t_wd = '{has: 1'b1, age: r_s2_age, idx: r_s2_idx};
            end
            S_AGE2: begin
                s_we = s2_rm;
                s_wa = r_s2_idx;
                s_wd = r_s2_word;
                s_wd.vld = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= RST_MAX_COUNT;
            r_full_life <= RST_FULL_LIFETIME;
            r_uc_mask   <= RST_UNICAST_MASK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_MAX_COUNT:     r_max_count <= i_cfg.data.data[10:0];
                CFG_FULL_LIFETIME: r_full_life <= i_cfg.data.data;
                CFG_UNICAST_MASK:  r_uc_mask   <= i_cfg.data.data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Request and search payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_mode  <= i_in.data.mode;
            r_id    <= i_in.data.entry_id;
            r_mac   <= i_in.data.mac_address;
            r_flags <= i_in.data.flag_bits;
            r_now   <= i_in.data.now_ticks;
        end
        if (r_state == S_SCAN && r_s1_v && s1_match) begin
            r_mslot     <= r_s1_idx;
            r_old_mac   <= s_rd.mac;
            r_old_flags <= s_rd.flags;
        end
        if (r_state == S_SCAN && r_s1_v && !s_rd.vld && !r_free_v) begin
            r_free <= r_s1_idx;
        end
        if (r_state == S_TCLR) begin
            if (cnt_x >= max_x) begin
                r_base <= SHORT_TMO;
            end else if (cnt_x >= (max_x >> 1)) begin
                r_base <= MID_TMO;
            end else begin
                r_base <= r_full_life;
            end
        end
        r_s1_idx  <= r_idx[IW-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_bkt  <= s_rd.bkt;
        r_s2_age  <= s1_age;
        r_s2_exp  <= s1_d[31];
        r_s2_word <= s_rd;
        r_fw_a    <= t_wa;
        r_fw_d    <= t_wd;
        if (r_state == S_FIN && (!r_ov || o_res.ready)) begin
            r_od.hit           <= r_hit;
            r_od.present       <= r_tgt_v;
            r_od.mac_out       <= r_tgt_v ? r_out_mac : 48'd0;
            r_od.flags_out     <= r_tgt_v ? r_out_flags : 16'd0;
            r_od.live_count    <= 11'(r_cnt);
            r_od.expired_count <= 11'(r_exp);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_tidx   <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_fw_v   <= 1'b0;
            r_rc     <= '0;
            r_cnt    <= '0;
            r_exp    <= '0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
            r_tgt_v  <= 1'b0;
            r_rem    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_fw_v <= (r_state == S_AGE1) && s2_upd;
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (IW+1)'(CAPACITY - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_hit    <= 1'b0;
                        r_free_v <= 1'b0;
                        r_exp    <= '0;
                        r_state  <= S_BKT;
                    end
                end
                S_BKT: begin
                    // Bucket is the low id bits
                    r_rem   <= r_id[BW-1:0] & BW'(BUCKETS - 1);
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_s1_v <= scan_issue;
                    if (r_s1_v && s1_match) begin
                        r_hit <= 1'b1;
                    end
                    if (r_s1_v && !s_rd.vld) begin
                        r_free_v <= 1'b1;
                    end
                    if (scan_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_out_mac   <= r_old_mac;
                    r_out_flags <= r_old_flags;
                    r_tgt_v     <= r_hit;
                    r_state     <= S_FIN;
                    if (r_mode && (r_id != 32'd0)) begin
                        r_out_mac   <= r_mac;
                        r_out_flags <= upd_flags;
                        r_tgt_v     <= r_hit || r_free_v;
                        r_tgt       <= r_hit ? r_mslot : r_free;
                        r_tidx      <= '0;
                        r_state     <= S_TCLR;
                        if (r_hit || r_free_v) begin
                            r_rc <= r_rc + 32'd1;
                        end
                        if (!r_hit && r_free_v) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_TCLR: begin
                    r_tidx <= r_tidx + 1'b1;
                    if (r_tidx == (BW+1)'(BUCKETS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_AGE1;
                    end
                end
                S_AGE1: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_s1_v <= scan_issue;
                    r_s2_v <= r_s1_v && s_rd.vld;
                    if (scan_done) begin
                        r_idx   <= '0;
                        r_state <= S_AGE2;
                    end
                end
                S_AGE2: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_s1_v <= scan_issue;
                    r_s2_v <= r_s1_v && s_rd.vld;
                    if (s2_rm) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_exp <= r_exp + 1'b1;
                        if (r_s2_idx == r_tgt) begin
                            r_tgt_v <= 1'b0;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
